// ===== hdl/ble_pkg.sv =====
// Shared types and constants for the battery level estimator.
// No dependencies; imported by ble_seg_sel and battery_level_estimator.
package ble_pkg;

  localparam int SAMPLE_W        = 12;
  localparam int MV_W            = 13;
  localparam int PCT_W           = 7;
  localparam int OFFS_W          = 9;
  localparam int RECIP_W         = 14;
  localparam int RECIP_SHIFT     = 16;
  localparam int AVG_SAMPLES_DEF = 16;
  localparam int ADC_FULL        = 4095;
  localparam int MV_SCALE        = 440;
  localparam int MV_DIV_UNIT     = 273;
  localparam int TABLE_POINTS    = 14;
  localparam int CRIT_RESET      = 5;

  localparam logic [MV_W-1:0] LVL_MV [TABLE_POINTS] = '{
    13'd3000, 13'd3500, 13'd3600, 13'd3700, 13'd3750, 13'd3800, 13'd3850,
    13'd3900, 13'd3950, 13'd4000, 13'd4050, 13'd4100, 13'd4150, 13'd4200
  };

  localparam logic [PCT_W-1:0] LVL_PCT [TABLE_POINTS] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
    7'd60, 7'd70, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100
  };

  // ceil(2^16 / (span / rise)) for each segment
  localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_POINTS-1] = '{
    14'd656, 14'd3277, 14'd6554, 14'd13108, 14'd13108, 14'd13108, 14'd13108,
    14'd13108, 14'd13108, 14'd6554, 14'd6554, 14'd6554, 14'd6554
  };

  typedef struct packed {
    logic [OFFS_W-1:0]  offset;
    logic [PCT_W-1:0]   base;
    logic [RECIP_W-1:0] recip;
  } seg_t;

endpackage

// ===== hdl/ble_seg_sel.sv =====
// Segment lookup of the LiPo discharge table for a millivolt value.
// Depends on ble_pkg for the table and the segment struct.
module ble_seg_sel
  import ble_pkg::*;
(
  input  logic [MV_W-1:0] mv,
  output seg_t            seg
);

  always_comb begin
    logic [3:0] idx;
    idx = '0;
    seg = '0;
    if (mv >= LVL_MV[TABLE_POINTS-1]) begin
      seg.base = LVL_PCT[TABLE_POINTS-1];
    end else if (mv > LVL_MV[0]) begin
      for (int k = 0; k < TABLE_POINTS - 1; k++) begin
        if (mv > LVL_MV[k]) begin
          idx = 4'(k);
        end
      end
      seg.offset = OFFS_W'(mv - LVL_MV[idx]);
      seg.base   = LVL_PCT[idx];
      seg.recip  = SEG_RECIP[idx];
    end
  end

endmodule

// ===== hdl/battery_level_estimator.sv =====
// Battery level estimator top level: averaging, millivolt scaling, percent mapping.
// Depends on ble_pkg and ble_seg_sel.
//
// Usage:
//   in_*  : one 12-bit ADC sample per transaction in in_tdata[11:0].
//   out_* : one result per AVG_SAMPLES input transactions;
//           out_tdata[12:0] millivolts, out_tdata[19:13] percent,
//           out_tuser[0] critical (percent below the threshold).
//   cfg_* : write of the 7-bit critical threshold, always ready.
// Samples are summed; the last sample of a group releases the sum into a
// six-stage pipeline (scale multiply, reciprocal multiply, back multiply,
// remainder correction, table segment lookup, interpolation). The sum is
// registered first, and out_tvalid is the valid of the interpolation stage.
// Throughput: one sample per cycle; each stage holds only while the stages
// after it are full and out_tready is low, so samples keep being taken while
// a result waits. in_tready drops only when every stage is full and stalled.
// Reset clears the sum, the sample count, all stage valids and sets the
// threshold to 5.
module battery_level_estimator
  import ble_pkg::*;
#(
  parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [12:0] millivolts, [19:13] percent
  output logic [0:0]  out_tuser,  // [0] critical
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // [6:0] critical_percent
);

  localparam int     SUM_W = $clog2(AVG_SAMPLES * ADC_FULL + 1);
  localparam int     CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam longint DIV   = longint'(AVG_SAMPLES) * MV_DIV_UNIT;
  localparam longint Y_MAX = longint'(AVG_SAMPLES) * ADC_FULL * MV_SCALE;
  localparam int     Y_W   = $clog2(Y_MAX + 1);
  localparam longint RECIP = (longint'(1) << Y_W) / DIV;
  localparam int     M_W   = $clog2(RECIP + 1);
  localparam int     P_W   = Y_W + M_W;
  localparam int     SP_W  = OFFS_W + RECIP_W;

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PCT_W-1:0] crit_r;

  logic             v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [SUM_W-1:0] gsum_r;
  logic [Y_W-1:0]   y2_r, y3_r, y4_r, qd4_r;
  logic [MV_W-1:0]  qe3_r, qe4_r, mv5_r, mv6_r;
  seg_t             seg6_r;
  logic             out_valid_r;
  logic [MV_W-1:0]  out_mv_r;
  logic [PCT_W-1:0] out_pct_r;
  logic             out_crit_r;

  logic             a1, a2, a3, a4, a5, a6, ao;
  logic             in_fire, last;
  logic [SUM_W-1:0] sum_nxt;
  logic [Y_W-1:0]   y_nxt;
  logic [P_W-1:0]   prod;
  logic [Y_W-1:0]   qd_nxt;
  logic [Y_W-1:0]   rem;
  logic [MV_W-1:0]  mv_nxt;
  seg_t             seg;
  logic [SP_W-1:0]  sp;
  logic [PCT_W-1:0] pct_nxt;

  assign ao = !out_valid_r || out_tready;
  assign a6 = !v6_r || ao;
  assign a5 = !v5_r || a6;
  assign a4 = !v4_r || a5;
  assign a3 = !v3_r || a4;
  assign a2 = !v2_r || a3;
  assign a1 = !v1_r || a2;

  assign in_tready = a1;
  assign in_fire   = in_tvalid && in_tready;
  assign last      = (cnt_r == CNT_W'(AVG_SAMPLES - 1));
  assign sum_nxt   = sum_r + SUM_W'(in_tdata[SAMPLE_W-1:0]);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      crit_r <= PCT_W'(CRIT_RESET);
    end else begin
      if (cfg_valid) begin
        crit_r <= cfg_data;
      end
      if (in_fire) begin
        if (last) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign y_nxt  = Y_W'(gsum_r) * Y_W'(MV_SCALE);
  assign prod   = P_W'(y2_r) * P_W'(RECIP);
  assign qd_nxt = Y_W'(qe3_r) * Y_W'(DIV);
  assign rem    = y4_r - qd4_r;
  assign mv_nxt = qe4_r + MV_W'(rem >= Y_W'(DIV));
  assign sp     = SP_W'(seg6_r.offset) * SP_W'(seg6_r.recip);
  assign pct_nxt = seg6_r.base + sp[RECIP_SHIFT +: PCT_W];

  ble_seg_sel u_seg_sel (
    .mv  (mv5_r),
    .seg (seg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a1) v1_r <= in_fire && last;
      if (a2) v2_r <= v1_r;
      if (a3) v3_r <= v2_r;
      if (a4) v4_r <= v3_r;
      if (a5) v5_r <= v4_r;
      if (a6) v6_r <= v5_r;
      if (ao) out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a1) gsum_r <= sum_nxt;
    if (a2) y2_r <= y_nxt;
    if (a3) begin
      y3_r  <= y2_r;
      qe3_r <= MV_W'(prod >> Y_W);
    end
    if (a4) begin
      y4_r  <= y3_r;
      qe4_r <= qe3_r;
      qd4_r <= qd_nxt;
    end
    if (a5) mv5_r <= mv_nxt;
    if (a6) begin
      mv6_r  <= mv5_r;
      seg6_r <= seg;
    end
    if (ao) begin
      out_mv_r   <= mv6_r;
      out_pct_r  <= pct_nxt;
      out_crit_r <= (pct_nxt < crit_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_pct_r, out_mv_r};
  assign out_tuser  = out_crit_r;

endmodule

// ===== hdl/ble_chk.sv =====
// Port-level checker for the battery level estimator, with its bind.
// Depends on battery_level_estimator ports only.
module ble_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:0] <= 13'd6600 && out_tdata[19:13] <= 7'd100)
    else $error("millivolts or percent out of range");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[19:13] == 7'd100) == (out_tdata[12:0] >= 13'd4200)))
    else $error("full charge does not match voltage");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:0] <= 13'd3000 |-> out_tdata[19:13] == 7'd0)
    else $error("nonzero percent at low voltage");

endmodule

bind battery_level_estimator ble_chk u_ble_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
